// ===== hdl/homogeneous_point_transform_unit_macros.svh =====
// assertion helpers for the point transform unit
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HPTU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hptu assertion failed");
`define HPTU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hptu assertion failed");
`else
`define HPTU_ASSERT_IMP(label, clk, rst, ante, cons)
`define HPTU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/hptu_pkg.sv =====
package hptu_pkg;

   // exact width of a four term row sum of 32 x 32 products
   localparam int SUM_W = 66;
   // quotient bits produced by the divide lanes
   localparam int Q_W = 33;
   localparam int ROW_STAGES = 3;
   localparam int DIV_STAGES = 2 + Q_W;
   localparam int PIPE_DEPTH = 1 + ROW_STAGES + DIV_STAGES;

   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic              func;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic              w_was_zero;
      logic              saturated;
   } rsp_type;

   typedef struct packed {
      logic [31:0] value;
      logic        clip;
      logic        wzero;
   } coord_type;

endpackage

// ===== hdl/homogeneous_point_transform_unit.sv =====
// channel   dir   handshake              payload
// req       in    req_valid/req_ready    req_data   (func, in_x, in_y, in_z)
// rsp       out   rsp_valid/rsp_ready    rsp_data   (out_x..z, w_was_zero, saturated)
// csr       in    csr_valid/csr_ready    csr_index, csr_data (one matrix row half)
//
// one request per cycle while the pipeline is not stalled; a request reaches rsp_data through the
// request register, the row lanes, the 33 step restoring divider that each coordinate lane runs through
// reset is synchronous and restores the identity matrix and empties the pipeline
// the pipeline keeps moving while a result waits in the output register, and
// stalls as a whole only once its last stage also holds a blocked request
module homogeneous_point_transform_unit import hptu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   `include "homogeneous_point_transform_unit_macros.svh"

   localparam int RW = SUM_W - FRAC_BITS;
   localparam int LAST = PIPE_DEPTH - 1;
   localparam logic [31:0] ONE = 32'(64'(1) << FRAC_BITS);

   // matrix coefficients, row then column
   logic [3:0][3:0][31:0] coef_ff;

   // pipeline occupancy, stage 0 is the request register
   logic [PIPE_DEPTH-1:0] pipe_v_ff, pipe_v_in;
   logic                  en, out_load;
   req_type               req_ff;
   logic [ROW_STAGES-1:0] func_ff;

   logic signed [RW-1:0] row [4];
   coord_type [2:0]      lane;
   rsp_type              merged;
   rsp_type              rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign csr_ready = 1'b1;

   // register i holds row i/2, columns 2*(i%2) and 2*(i%2)+1
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               coef_ff[i][j] <= (i == j) ? ONE : 32'd0;
            end
         end
      end else if (csr_valid && csr_ready) begin
         coef_ff[csr_index[2:1]][{csr_index[0], 1'b0}] <= csr_data[31:0];
         coef_ff[csr_index[2:1]][{csr_index[0], 1'b1}] <= csr_data[63:32];
      end
   end

   // output register frees up when empty or taken
   assign out_load = ~rsp_valid_ff | rsp_ready;
   // pipeline moves unless its last stage is blocked behind the output register
   assign en        = ~pipe_v_ff[LAST] | out_load;
   assign req_ready = en;

   assign pipe_v_in    = en ? {pipe_v_ff[LAST-1:0], req_valid} : pipe_v_ff;
   assign rsp_valid_in = out_load ? pipe_v_ff[LAST] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pipe_v_ff    <= pipe_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request register and mode bit carried alongside the row lanes
   always_ff @(posedge clock) begin
      if (en) begin
         req_ff  <= req_data;
         func_ff <= {func_ff[ROW_STAGES-2:0], req_ff.func};
      end
   end

   // one dot product lane per matrix row
   for (genvar i = 0; i < 4; i++) begin : g_row
      hptu_row_lane #(.FRAC_BITS(FRAC_BITS)) u_row (
         .clock (clock),
         .en    (en),
         .func  (req_ff.func),
         .coef  (coef_ff[i]),
         .x     (req_ff.in_x),
         .y     (req_ff.in_y),
         .z     (req_ff.in_z),
         .row   (row[i])
      );
   end

   // one divide lane per output coordinate, all sharing w from row 3
   for (genvar i = 0; i < 3; i++) begin : g_div
      hptu_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .func  (func_ff[ROW_STAGES-1]),
         .r     (row[i]),
         .w     (row[3]),
         .res   (lane[i])
      );
   end

   // gather coordinates and flags
   hptu_merge u_merge (
      .lane (lane),
      .rsp  (merged)
   );

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a blocked request in the last stage is never dropped
   `HPTU_ASSERT_NXT(a_last_hold, clock, reset, pipe_v_ff[LAST] && rsp_valid && !rsp_ready, pipe_v_ff[LAST])
   // nothing comes out straight after reset
   `HPTU_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // a zero w with any nonzero coordinate is flagged as clipped
   `HPTU_ASSERT_IMP(a_wzero_sat, clock, reset, rsp_valid && rsp_data.w_was_zero && (rsp_data.out_x != 0 || rsp_data.out_y != 0 || rsp_data.out_z != 0), rsp_data.saturated)

endmodule

// ===== hdl/hptu_row_lane.sv =====
module hptu_row_lane import hptu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic                                func,
   input  logic [3:0][31:0]                    coef,
   input  logic signed [31:0]                  x,
   input  logic signed [31:0]                  y,
   input  logic signed [31:0]                  z,
   output logic signed [SUM_W-FRAC_BITS-1:0]  row
);

   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(66'(1) << (FRAC_BITS - 1));

   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [63:0] p3_in;
   logic signed [64:0] s01_ff, s23_ff;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-FRAC_BITS-1:0] row_ff;

   // translation column weighted by w = 1.0, a plain shift
   assign p3_in = func ? 64'sd0 : (64'(signed'(coef[3])) <<< FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= signed'(coef[0]) * x;
         p1_ff  <= signed'(coef[1]) * y;
         p2_ff  <= signed'(coef[2]) * z;
         p3_ff  <= p3_in;
         s01_ff <= 65'(p0_ff) + 65'(p1_ff);
         s23_ff <= 65'(p2_ff) + 65'(p3_ff);
         row_ff <= sum[SUM_W-1:FRAC_BITS];
      end
   end

   // round half up, then floor by dropping fraction bits
   assign sum = SUM_W'(s01_ff) + SUM_W'(s23_ff) + HALF;
   assign row = row_ff;

endmodule

// ===== hdl/hptu_div_lane.sv =====
module hptu_div_lane import hptu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic                               func,
   input  logic signed [SUM_W-FRAC_BITS-1:0] r,
   input  logic signed [SUM_W-FRAC_BITS-1:0] w,
   output coord_type                          res
);

   localparam int MW = SUM_W - FRAC_BITS;
   localparam int RM = MW + 1;
   localparam int HI_W = SUM_W - Q_W;
   localparam logic [Q_W-1:0] NEG_LIM = Q_W'(64'h8000_0000);

   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic        byp;
      logic        clip;
      logic        wz;
      logic [31:0] val;
   } side_type;

   logic          r_neg, w_neg, fits, wz;
   logic [31:0]   sat_val, byp_val;
   logic          byp_clip;
   side_type      a_side_ff;
   logic [MW-1:0] a_rmag_ff, a_dmag_ff;
   logic [SUM_W-1:0] num;
   logic [HI_W-1:0]  num_hi;
   logic             a_ovf;

   side_type         side_ff [Q_W+1];
   logic [MW-1:0]    d_ff    [Q_W+1];
   logic [RM-1:0]    rem_ff  [Q_W+1];
   logic [Q_W-1:0]   low_ff  [Q_W+1];
   logic [Q_W-1:0]   q_ff    [Q_W+1];

   assign r_neg = r[MW-1];
   assign w_neg = w[MW-1];
   assign wz    = (w == '0);
   assign fits  = (&r[MW-1:31]) | ~(|r[MW-1:31]);
   assign sat_val = fits ? r[31:0] : (r_neg ? SAT_MIN : SAT_MAX);

   always_comb begin
      if (func) begin
         byp_val  = sat_val;
         byp_clip = ~fits;
      end else begin
         byp_val  = (r == '0) ? 32'd0 : (r_neg ? SAT_MIN : SAT_MAX);
         byp_clip = (r != '0);
      end
   end

   // magnitudes and bypass results
   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff.neg  <= r_neg ^ w_neg;
         a_side_ff.ovf  <= 1'b0;
         a_side_ff.byp  <= func | wz;
         a_side_ff.clip <= byp_clip;
         a_side_ff.wz   <= ~func & wz;
         a_side_ff.val  <= byp_val;
         a_rmag_ff      <= r_neg ? MW'(-r) : MW'(r);
         a_dmag_ff      <= w_neg ? MW'(-w) : MW'(w);
      end
   end

   assign num    = SUM_W'(a_rmag_ff) << FRAC_BITS;
   assign num_hi = num[SUM_W-1:Q_W];

   // quotient of 2^33 or more saturates whatever the sign
   assign a_ovf = RM'(num_hi) >= RM'(a_dmag_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0]     <= '{neg: a_side_ff.neg, ovf: a_ovf, byp: a_side_ff.byp,
                             clip: a_side_ff.clip, wz: a_side_ff.wz, val: a_side_ff.val};
         d_ff[0]        <= a_dmag_ff;
         rem_ff[0]      <= RM'(num_hi);
         low_ff[0]      <= num[Q_W-1:0];
         q_ff[0]        <= '0;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_step
      logic [RM-1:0] t;
      logic          ge;
      assign t  = {rem_ff[k-1][RM-2:0], low_ff[k-1][Q_W-1]};
      assign ge = t >= RM'(d_ff[k-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
            d_ff[k]    <= d_ff[k-1];
            rem_ff[k]  <= ge ? (t - RM'(d_ff[k-1])) : t;
            low_ff[k]  <= {low_ff[k-1][Q_W-2:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][Q_W-2:0], ge};
         end
      end
   end

   always_comb begin
      res.wzero = side_ff[Q_W].wz;
      if (side_ff[Q_W].byp) begin
         res.value = side_ff[Q_W].val;
         res.clip  = side_ff[Q_W].clip;
      end else if (side_ff[Q_W].neg) begin
         if (side_ff[Q_W].ovf || (q_ff[Q_W] > NEG_LIM)) begin
            res.value = SAT_MIN;
            res.clip  = 1'b1;
         end else begin
            res.value = 32'(-q_ff[Q_W]);
            res.clip  = 1'b0;
         end
      end else begin
         if (side_ff[Q_W].ovf || q_ff[Q_W][Q_W-1] || q_ff[Q_W][31]) begin
            res.value = SAT_MAX;
            res.clip  = 1'b1;
         end else begin
            res.value = q_ff[Q_W][31:0];
            res.clip  = 1'b0;
         end
      end
   end

endmodule

// ===== hdl/hptu_merge.sv =====
module hptu_merge import hptu_pkg::*; (
   input  coord_type [2:0] lane,
   output rsp_type         rsp
);

   always_comb begin
      rsp.out_x      = lane[0].value;
      rsp.out_y      = lane[1].value;
      rsp.out_z      = lane[2].value;
      rsp.w_was_zero = lane[0].wzero;
      rsp.saturated  = lane[0].clip | lane[1].clip | lane[2].clip;
   end

endmodule

// ===== tb/sv/homogeneous_point_transform_unit_test.sv =====
`timescale 1ns / 100ps

module homogeneous_point_transform_unit_test;
   import hptu_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 40;

   // csr register indexes, one per matrix row half
   localparam logic [2:0] REG_R0C01 = 3'd0;
   localparam logic [2:0] REG_R0C23 = 3'd1;
   localparam logic [2:0] REG_R1C01 = 3'd2;
   localparam logic [2:0] REG_R1C23 = 3'd3;
   localparam logic [2:0] REG_R2C01 = 3'd4;
   localparam logic [2:0] REG_R2C23 = 3'd5;
   localparam logic [2:0] REG_R3C01 = 3'd6;
   localparam logic [2:0] REG_R3C23 = 3'd7;

   // transform modes
   localparam logic FUNC_POINT = 1'b0;
   localparam logic FUNC_DIR   = 1'b1;

   localparam logic signed [31:0] ONE_Q = 32'sd65536;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // our own copy of the matrix
   logic signed [31:0] matrix [4][4];
   rsp_type expected_q[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   homogeneous_point_transform_unit #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous fixed time limit
   initial begin
      #(12 * 400000);
      $display("TB_ERROR");
      $finish;
   end

   // exact row sum of products, rounded half up to FRAC fraction bits
   function automatic logic signed [69:0] row_round(int r, logic signed [31:0] v0,
         logic signed [31:0] v1, logic signed [31:0] v2, bit with_w);
      logic signed [69:0] acc;
      acc = 70'(matrix[r][0]) * 70'(v0) + 70'(matrix[r][1]) * 70'(v1)
          + 70'(matrix[r][2]) * 70'(v2);
      if (with_w) acc = acc + 70'(matrix[r][3]) * 70'(ONE_Q);
      acc = acc + (70'sd1 <<< (FRAC - 1));
      return acc >>> FRAC;
   endfunction

   function automatic logic signed [31:0] clip32(logic signed [69:0] v, ref bit clip);
      if (v > 70'(MAX32)) begin
         clip = 1'b1;
         return 32'h7fff_ffff;
      end
      if (v < 70'(MIN32)) begin
         clip = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // quotient truncated toward zero then saturated
   function automatic logic signed [31:0] divide_clip(logic signed [69:0] num,
         logic signed [69:0] w, ref bit clip);
      logic [139:0] n, d, q;
      bit neg;
      neg = (num < 0) != (w < 0);
      n = 140'(num < 0 ? -num : num) << FRAC;
      d = 140'(w < 0 ? -w : w);
      q = n / d;
      if (neg) begin
         if (q > 140'd2147483648) begin
            clip = 1'b1;
            return 32'h8000_0000;
         end
         return -$signed(q[32:0]);
      end
      if (q > 140'd2147483647) begin
         clip = 1'b1;
         return 32'h7fff_ffff;
      end
      return q[31:0];
   endfunction

   function automatic rsp_type transform_point(req_type rq);
      rsp_type rs;
      logic signed [69:0] r [3];
      logic signed [69:0] w;
      bit clip;
      clip = 1'b0;
      rs = '0;
      if (rq.func == FUNC_DIR) begin
         rs.out_x = clip32(row_round(0, rq.in_x, rq.in_y, rq.in_z, 0), clip);
         rs.out_y = clip32(row_round(1, rq.in_x, rq.in_y, rq.in_z, 0), clip);
         rs.out_z = clip32(row_round(2, rq.in_x, rq.in_y, rq.in_z, 0), clip);
      end else begin
         for (int i = 0; i < 3; i++) r[i] = row_round(i, rq.in_x, rq.in_y, rq.in_z, 1);
         w = row_round(3, rq.in_x, rq.in_y, rq.in_z, 1);
         if (w == 0) begin
            rs.w_was_zero = 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (r[i] != 0) clip = 1'b1;
            end
            rs.out_x = r[0] > 0 ? 32'h7fff_ffff : r[0] < 0 ? 32'h8000_0000 : 32'h0;
            rs.out_y = r[1] > 0 ? 32'h7fff_ffff : r[1] < 0 ? 32'h8000_0000 : 32'h0;
            rs.out_z = r[2] > 0 ? 32'h7fff_ffff : r[2] < 0 ? 32'h8000_0000 : 32'h0;
         end else begin
            rs.out_x = divide_clip(r[0], w, clip);
            rs.out_y = divide_clip(r[1], w, clip);
            rs.out_z = divide_clip(r[2], w, clip);
         end
      end
      rs.saturated = clip;
      return rs;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   // result checker and receiver stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.out_x, 32'h0);
            end else begin
               rsp_type e;
               e = expected_q.pop_front();
               if (rsp_data.out_x !== e.out_x) report_mismatch("out_x", rsp_data.out_x, e.out_x);
               if (rsp_data.out_y !== e.out_y) report_mismatch("out_y", rsp_data.out_y, e.out_y);
               if (rsp_data.out_z !== e.out_z) report_mismatch("out_z", rsp_data.out_z, e.out_z);
               if (rsp_data.w_was_zero !== e.w_was_zero)
                  report_mismatch("w_was_zero", 32'(rsp_data.w_was_zero), 32'(e.w_was_zero));
               if (rsp_data.saturated !== e.saturated)
                  report_mismatch("saturated", 32'(rsp_data.saturated), 32'(e.saturated));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // send one request, with a random idle gap before it; valid stays up
   // after the request is taken until the next idle cycle or wait
   task automatic send_request(logic func, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type rq;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      rq.func = func;
      rq.in_x = x;
      rq.in_y = y;
      rq.in_z = z;
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(transform_point(rq));
   endtask

   // let the pipeline empty fully before touching the matrix
   task automatic drain_pipeline();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      matrix[idx >> 1][(idx & 1) * 2]     = value[31:0];
      matrix[idx >> 1][(idx & 1) * 2 + 1] = value[63:32];
   endtask

   task automatic load_matrix(logic [63:0] v [8]);
      drain_pipeline();
      write_csr(REG_R0C01, v[0]);
      write_csr(REG_R0C23, v[1]);
      write_csr(REG_R1C01, v[2]);
      write_csr(REG_R1C23, v[3]);
      write_csr(REG_R2C01, v[4]);
      write_csr(REG_R2C23, v[5]);
      write_csr(REG_R3C01, v[6]);
      write_csr(REG_R3C23, v[7]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
         2: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
         3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         4: return 32'($signed($urandom_range(8)) - 4);
         default: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
         2: return 32'h0;
         3: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
         default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   task automatic test_identity_directed();
      send_request(FUNC_POINT, 32'h0, 32'h0, 32'h0);
      send_request(FUNC_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      send_request(FUNC_DIR, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
      send_request(FUNC_POINT, ONE_Q, -ONE_Q, 32'h0003_8000);
      send_request(FUNC_DIR, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
   endtask

   // zero w row: w_was_zero with positive, negative and zero numerators
   task automatic test_w_zero();
      logic [63:0] v [8];
      v = '{64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
            64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
            64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
            64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000};
      v[2][63:32] = 32'hffff_0000;
      load_matrix(v);
      send_request(FUNC_POINT, ONE_Q, ONE_Q, 32'h0);
      send_request(FUNC_POINT, 32'h0, 32'h0, 32'h0);
      send_request(FUNC_POINT, -ONE_Q, 32'h8000_0000, 32'h7fff_ffff);
      send_request(FUNC_DIR, ONE_Q, ONE_Q, ONE_Q);
      // w tiny: rounds to zero for the first request and to one for the second
      v[7] = 64'h0000_0000_0000_0000;
      v[6] = 64'h0000_0000_0000_0001;
      load_matrix(v);
      send_request(FUNC_POINT, 32'h0000_4000, ONE_Q, 32'h0);
      send_request(FUNC_POINT, 32'h0000_8000, 32'h0, 32'h0);
   endtask

   // extreme coefficients and small w: overflow and clipping
   task automatic test_extremes();
      logic [63:0] v [8];
      v = '{64'h7fff_ffff_8000_0000, 64'h7fff_ffff_8000_0000,
            64'h8000_0000_7fff_ffff, 64'h8000_0000_7fff_ffff,
            64'h7fff_ffff_7fff_ffff, 64'h8000_0000_8000_0000,
            64'h0000_0000_0000_0000, 64'h0000_0001_0000_0000};
      load_matrix(v);
      send_request(FUNC_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_request(FUNC_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(FUNC_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(FUNC_DIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(FUNC_POINT, ONE_Q, 32'h0, 32'h0);
      v[7] = 64'h8000_0000_0000_0000;
      load_matrix(v);
      send_request(FUNC_POINT, 32'h0, 32'h0, 32'h0);
      send_request(FUNC_POINT, ONE_Q, ONE_Q, ONE_Q);
      send_request(FUNC_DIR, 32'h0000_0001, 32'hffff_ffff, 32'h0);
   endtask

   // random matrices and requests under each idling phase
   task automatic test_random_phase(int sidle, int rstall, int n_items);
      logic [63:0] v [8];
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      for (int m = 0; m < 4; m++) begin
         for (int k = 0; k < 8; k++) v[k] = {rand_coef(), rand_coef()};
         // mostly a w row near one so the divide gives usable results
         if ($urandom_range(3) != 0) begin
            v[6] = {32'($signed($urandom_range(512)) - 256), 32'($signed($urandom_range(512)) - 256)};
            v[7] = {32'($signed($urandom_range(1 << 18))), 32'($signed($urandom_range(512)) - 256)};
         end
         load_matrix(v);
         for (int i = 0; i < n_items / 4; i++) begin
            send_request($urandom_range(1), rand_coord(), rand_coord(), rand_coord());
            // pressure: sometimes wait for everything outstanding
            if (i == n_items / 8) begin
               req_valid <= 1'b0;
               while (expected_q.size() != 0) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_R0C01;
      csr_data = '0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) matrix[i][j] = (i == j) ? ONE_Q : 32'sh0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_directed();
      test_w_zero();
      test_extremes();
      test_random_phase(0, 0, 420);
      test_random_phase(51, 0, 420);
      test_random_phase(0, 51, 420);
      test_random_phase(14, 14, 420);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_pipeline();
      if (expected_q.size() != 0) begin
         error_count++;
         $display("responses still outstanding: %0d", expected_q.size());
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
